// ----- design/drrip_pkg.sv -----
// Package: sizes, sequencer states and helpers for the DRRIP/SHiP replacement block.
`timescale 1ns / 1ps
package drrip_pkg;
  localparam int NumSets     = 2048;
  localparam int NumWays     = 16;
  localparam int SigWidth    = 6;
  localparam int SigEntries  = 1 << SigWidth;
  localparam int StreamSets  = 32;
  localparam int DuelLeaders = 16;
  localparam int SetW        = $clog2(NumSets);
  localparam int WayW        = $clog2(NumWays);
  localparam int StrW        = $clog2(StreamSets);
  localparam int AddrW       = 64;

  localparam logic [1:0] RrpvMax = 2'd3;
  localparam logic [1:0] CtrMax  = 2'd3;
  localparam logic [2:0] RepMax  = 3'd7;
  localparam logic [9:0] SelMid  = 10'd512;
  localparam logic [9:0] SelMax  = 10'd1023;

  typedef logic [NumWays*2-1:0]        rrpv_row_t;
  typedef logic [NumWays*SigWidth-1:0] sig_row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2
  } state_e;

  typedef enum logic [7:0] {
    CFG_STREAM_THR = 8'd0,
    CFG_CONF_THR   = 8'd1
  } cfg_idx_e;

  function automatic logic [SigWidth-1:0] sig_hash(input logic [63:0] pc);
    sig_hash = pc[SigWidth-1:0] ^ pc[2*SigWidth-1:SigWidth] ^ pc[3*SigWidth-1:2*SigWidth];
  endfunction
endpackage

// ----- design/drrip_ship_stream_replacement.sv -----
// Top level: DRRIP replacement with signature predictor and stream detector.
`timescale 1ns / 1ps
// Sequence: an accepted word goes through row and new-counter read, old-counter read and
//   execute before its result word is registered; no new word is taken until the sequencer
//   is back in idle, as the set-row and signature-counter memories have a single read port.
// Reset: asynchronous, active low; afterwards a clearing pass over all 2048 sets zeroes
//   the set rows and counters, during which no input word is taken.
module drrip_ship_stream_replacement (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // fields low to high: set_index[10:0], way_index[14:11], valid_mask[30:15],
  // program_counter[94:31], phys_addr[158:95], zero pad [159]
  input  logic [159:0] s_axis_tdata_i,
  // fields low to high: action[0], was_hit[1]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // fields low to high: victim_way[3:0], inserted_rrpv[5:4], bypass_taken[6], zero [7]
  output logic [7:0]   m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);
  import drrip_pkg::*;

  // Set rows and signature counters live in memories with registered reads.
  rrpv_row_t           rrpv_mem [NumSets];
  sig_row_t            sig_mem  [NumSets];
  logic [1:0]          ctr_mem  [SigEntries];

  state_e              state_q, state_d;
  logic [SetW-1:0]     clr_q;
  logic                in_acc;

  // Latched input word.
  logic                act_q, hit_q;
  logic [SetW-1:0]     set_q;
  logic [WayW-1:0]     way_q;
  logic [NumWays-1:0]  mask_q;
  logic [SigWidth-1:0] sig_q;
  logic [AddrW-1:0]    addr_q;

  rrpv_row_t           rrpv_rd_q;
  sig_row_t            sig_rd_q;
  logic [1:0]          ctr_rd_q, ctr_new_q;
  logic                stream_q;

  // Stream detector for the leader sets.
  logic [AddrW-1:0]    last_addr_q   [StreamSets];
  logic [AddrW-1:0]    last_stride_q [StreamSets];
  logic [2:0]          rep_q         [StreamSets];
  logic [9:0]          sel_q;
  logic [2:0]          stream_thr_q;
  logic [1:0]          conf_thr_q;

  logic                out_valid_q;
  logic [7:0]          out_data_q;

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Next state: clear pass, then fixed walk accept and row read -> counter read -> execute.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SetW'(NumSets - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Counter memory address: new signature on accept, old one in the counter-read step.
  logic [SigWidth-1:0] ctr_addr;
  logic [SigWidth-1:0] old_sig;
  assign old_sig = sig_rd_q[way_q*SigWidth +: SigWidth];
  always_comb begin
    if (state_q == ST_IDLE) begin
      ctr_addr = sig_hash(s_axis_tdata_i[94:31]);
    end else begin
      ctr_addr = old_sig;
    end
  end

  // Execute step.
  logic [StrW-1:0]  sidx;
  logic             is_stream_set, srrip_lead, brrip_lead;
  logic [AddrW-1:0] stride;
  logic             rep_match;
  logic [2:0]       rep_new;
  logic [1:0]       top, ins, depth;
  logic             any_inv;
  logic [WayW-1:0]  inv_way, vic_way;
  rrpv_row_t        aged_row, upd_row;
  sig_row_t         upd_sig;

  assign sidx          = set_q[StrW-1:0];
  assign is_stream_set = set_q < SetW'(StreamSets);
  assign srrip_lead    = set_q < SetW'(DuelLeaders);
  assign brrip_lead    = !srrip_lead && (set_q < SetW'(2 * DuelLeaders));
  assign stride        = addr_q - last_addr_q[sidx];
  assign rep_match     = (last_stride_q[sidx] != '0) && (stride == last_stride_q[sidx]);
  assign rep_new       = rep_match ? ((rep_q[sidx] < RepMax) ? rep_q[sidx] + 3'd1
                                                              : rep_q[sidx]) : 3'd0;

  always_comb begin
    any_inv = 1'b0;
    inv_way = '0;
    top     = '0;
    vic_way = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (!mask_q[w]) begin
        any_inv = 1'b1;
        inv_way = WayW'(w);
      end
    end
    for (int w = 0; w < NumWays; w++) begin
      if (rrpv_rd_q[2*w +: 2] > top) top = rrpv_rd_q[2*w +: 2];
    end
    for (int w = 0; w < NumWays; w++) begin
      aged_row[2*w +: 2] = rrpv_rd_q[2*w +: 2] + (RrpvMax - top);
    end
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (aged_row[2*w +: 2] == RrpvMax) vic_way = WayW'(w);
    end
  end

  always_comb begin
    depth = srrip_lead ? 2'd2 : (brrip_lead ? 2'd3 : ((sel_q >= SelMid) ? 2'd3 : 2'd2));
    if (stream_q) begin
      ins = RrpvMax;
    end else if (ctr_new_q >= conf_thr_q) begin
      ins = 2'd0;
    end else begin
      ins = depth;
    end
    upd_row = rrpv_rd_q;
    upd_sig = sig_rd_q;
    upd_row[way_q*2 +: 2]               = hit_q ? 2'd0 : ins;
    upd_sig[way_q*SigWidth +: SigWidth] = sig_q;
  end

  // Memories: clear pass, or at most one write per memory in the execute step.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      rrpv_mem[clr_q] <= '0;
      sig_mem[clr_q]  <= '0;
      ctr_mem[clr_q[SigWidth-1:0]] <= '0;
    end else if (state_q == ST_RD2) begin
      if (!act_q) begin
        if (!any_inv) rrpv_mem[set_q] <= aged_row;
      end else begin
        rrpv_mem[set_q] <= upd_row;
        sig_mem[set_q]  <= upd_sig;
        if (hit_q) begin
          if (ctr_new_q < CtrMax) ctr_mem[sig_q] <= ctr_new_q + 2'd1;
        end else if (ctr_rd_q != 2'd0) begin
          ctr_mem[old_sig] <= ctr_rd_q - 2'd1;
        end
      end
    end
    if (in_acc) begin
      rrpv_rd_q <= rrpv_mem[s_axis_tdata_i[10:0]];
      sig_rd_q  <= sig_mem[s_axis_tdata_i[10:0]];
    end
    if (state_q == ST_IDLE || state_q == ST_RD1) ctr_rd_q <= ctr_mem[ctr_addr];
  end

  // Payload latches.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= s_axis_tuser_i[0];
      hit_q  <= s_axis_tuser_i[1];
      set_q  <= s_axis_tdata_i[10:0];
      way_q  <= s_axis_tdata_i[14:11];
      mask_q <= s_axis_tdata_i[30:15];
      sig_q  <= sig_hash(s_axis_tdata_i[94:31]);
      addr_q <= s_axis_tdata_i[158:95];
    end
    if (state_q == ST_RD1) begin
      ctr_new_q <= ctr_rd_q;
      stream_q  <= act_q && is_stream_set && (rep_new >= stream_thr_q);
    end
    if (state_q == ST_RD2) begin
      if (!act_q) begin
        out_data_q <= {4'd0, any_inv ? inv_way : vic_way};
      end else begin
        out_data_q <= {1'b0, stream_q && !hit_q, hit_q ? 2'd0 : ins, 4'd0};
      end
    end
  end

  // Control state, stream tables, selector and registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      sel_q        <= SelMid;
      stream_thr_q <= 3'd4;
      conf_thr_q   <= 2'd2;
      for (int i = 0; i < StreamSets; i++) begin
        last_addr_q[i]   <= '0;
        last_stride_q[i] <= '0;
        rep_q[i]         <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + SetW'(1);
      if (state_q == ST_RD2) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      // Advance the stride detector once per update word in a leader set.
      if (state_q == ST_RD1 && act_q && is_stream_set) begin
        rep_q[sidx]         <= rep_new;
        last_stride_q[sidx] <= stride;
        last_addr_q[sidx]   <= addr_q;
      end
      // Steer the selector on non-streaming misses in leader sets.
      if (state_q == ST_RD2 && act_q && !hit_q && !stream_q) begin
        if (srrip_lead && sel_q < SelMax) sel_q <= sel_q + 10'd1;
        if (brrip_lead && sel_q > 10'd0)  sel_q <= sel_q - 10'd1;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_STREAM_THR) stream_thr_q <= cfg_data_i[2:0];
        if (cfg_index_i == CFG_CONF_THR)   conf_thr_q   <= cfg_data_i[1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_acc_to_rd1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_RD1) else $error("accept did not start row read");
  a_rd1_to_rd2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD1 |=> state_q == ST_RD2) else $error("counter read skipped");
  a_rd2_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD2 |=> m_axis_tvalid_o) else $error("result word not raised");
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready_o) else $error("input taken during clear");
`endif
endmodule

// ----- tb/drrip_replacement_checker.sv -----
// Checker: watches the stream and config channels, predicts each result word and compares.
`timescale 1ns / 1ps
module drrip_replacement_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [159:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [7:0]   m_axis_tdata_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [7:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  output int           pending_o,
  output int           fails_o,
  output int           checked_o
);
  import drrip_pkg::*;

  // Packed from the top bit down: bypass[6], rrpv[5:4], victim[3:0].
  typedef struct packed {
    logic       bypass;
    logic [1:0] rrpv;
    logic [3:0] victim;
  } policy_word_t;

  bit [1:0]  way_rrpv[NumSets][NumWays];
  bit [5:0]  way_sig[NumSets][NumWays];
  bit [1:0]  reuse_ctr[SigEntries];
  bit [63:0] prev_addr[StreamSets];
  bit [63:0] prev_stride[StreamSets];
  bit [2:0]  stride_hits[StreamSets];
  bit [9:0]  psel;
  bit [2:0]  stream_thr;
  bit [1:0]  conf_thr;

  policy_word_t expected_words[$];

  initial begin
    psel       = 10'd512;
    stream_thr = 3'd4;
    conf_thr   = 2'd2;
    fails_o    = 0;
    checked_o  = 0;
  end

  assign pending_o = expected_words.size();

  // Pick a victim, aging the set when every way is valid.
  function automatic policy_word_t pick_victim(int set, bit [15:0] mask);
    policy_word_t r;
    bit [1:0] top;
    r   = '0;
    top = 0;
    for (int w = 0; w < NumWays; w++)
      if (!mask[w]) begin
        r.victim = 4'(w);
        return r;
      end
    for (int w = 0; w < NumWays; w++)
      if (way_rrpv[set][w] > top) top = way_rrpv[set][w];
    for (int w = 0; w < NumWays; w++) way_rrpv[set][w] += 2'd3 - top;
    for (int w = NumWays - 1; w >= 0; w--)
      if (way_rrpv[set][w] == 2'd3) r.victim = 4'(w);
    return r;
  endfunction

  // Apply a hit or fill and return the inserted depth.
  function automatic policy_word_t apply_update(int set, int way, bit [63:0] pc,
                                                bit [63:0] addr, bit hit);
    policy_word_t r;
    bit [5:0]  sig, old;
    bit [63:0] stride;
    bit        streaming, srrip_lead, brrip_lead;
    bit [1:0]  depth;
    r         = '0;
    streaming = 0;
    sig       = 6'((pc ^ (pc >> 6) ^ (pc >> 12)) & 64'h3f);
    if (set < StreamSets) begin
      stride = addr - prev_addr[set];
      if (prev_stride[set] != 0 && stride == prev_stride[set]) begin
        if (stride_hits[set] != 3'd7) stride_hits[set]++;
      end else begin
        stride_hits[set] = 0;
      end
      prev_stride[set] = stride;
      prev_addr[set]   = addr;
      streaming        = stride_hits[set] >= stream_thr;
    end
    if (hit) begin
      way_rrpv[set][way] = 0;
      way_sig[set][way]  = sig;
      if (reuse_ctr[sig] != 2'd3) reuse_ctr[sig]++;
      return r;
    end
    srrip_lead = set < DuelLeaders;
    brrip_lead = !srrip_lead && set < 2 * DuelLeaders;
    if (streaming) begin
      depth = 2'd3;
    end else begin
      if (srrip_lead)      depth = 2'd2;
      else if (brrip_lead) depth = 2'd3;
      else                 depth = (psel >= 10'd512) ? 2'd3 : 2'd2;
      if (reuse_ctr[sig] >= conf_thr) depth = 2'd0;
    end
    // decay the evicted block's signature before overwriting it
    old = way_sig[set][way];
    if (reuse_ctr[old] != 0) reuse_ctr[old]--;
    way_rrpv[set][way] = depth;
    way_sig[set][way]  = sig;
    if (!streaming) begin
      if (srrip_lead && psel != 10'd1023) psel++;
      if (brrip_lead && psel != 10'd0)    psel--;
    end
    r.rrpv   = depth;
    r.bypass = streaming;
    return r;
  endfunction

  always @(posedge clk_i) begin
    policy_word_t exp_w, got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_STREAM_THR)    stream_thr = cfg_data_i[2:0];
        else if (cfg_index_i == CFG_CONF_THR) conf_thr   = cfg_data_i[1:0];
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (!s_axis_tuser_i[0])
          expected_words.insert(expected_words.size(),
                                pick_victim(s_axis_tdata_i[10:0], s_axis_tdata_i[30:15]));
        else
          expected_words.insert(expected_words.size(),
                                apply_update(s_axis_tdata_i[10:0], s_axis_tdata_i[14:11],
                                             s_axis_tdata_i[94:31], s_axis_tdata_i[158:95],
                                             s_axis_tuser_i[1]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[6:0];
        if (expected_words.size() == 0) begin
          $error("result word with no expectation: %h", m_axis_tdata_i);
          fails_o++;
        end else begin
          exp_w = expected_words.pop_front();
          checked_o++;
          if (got.victim !== exp_w.victim) begin
            $error("victim_way: expected %0d, got %0d", exp_w.victim, got.victim);
            fails_o++;
          end
          if (got.rrpv !== exp_w.rrpv) begin
            $error("inserted_rrpv: expected %0d, got %0d", exp_w.rrpv, got.rrpv);
            fails_o++;
          end
          if (got.bypass !== exp_w.bypass) begin
            $error("bypass_taken: expected %0d, got %0d", exp_w.bypass, got.bypass);
            fails_o++;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb.sv -----
// Testbench top: drives stimulus and config phases, gives the verdict.
`timescale 1ns / 1ps
module tb;
  import drrip_pkg::*;

  localparam int TimeoutCycles = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i;  // set, way, valid_mask, pc, addr, pad (low to high)
  logic [1:0]   s_axis_tuser_i;  // action, was_hit (low to high)
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [7:0]   m_axis_tdata_o;  // victim_way, inserted_rrpv, bypass_taken, pad
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [7:0]   cfg_data_i;

  int pending, fails, checked;
  int words_sent;
  int cycle_count;

  // Per-stream-set address walk for well-formed strided sequences.
  bit [63:0] walk_addr[StreamSets];
  bit [63:0] walk_stride[StreamSets];
  bit [63:0] hot_pcs[8];

  drrip_ship_stream_replacement u_top (.*);

  drrip_replacement_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fails_o(fails), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > TimeoutCycles) begin
        $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
        $display("** drrip_ship_stream_replacement: FAILED **");
        $finish;
      end
    end
  end

  // Result side: drop ready for a random stall, possibly none, before taking each word.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i iff m_axis_tvalid_o);
    end
  end

  // Send one word after a random gap; hold until accepted.
  task automatic send_word(bit act, bit [10:0] set, bit [3:0] way, bit [15:0] mask,
                           bit [63:0] pc, bit [63:0] addr, bit hit);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, addr, pc, mask, way, set};
    s_axis_tuser_i  <= {hit, act};
    @(posedge clk_i iff s_axis_tready_o);
    words_sent++;
  endtask

  task automatic write_reg(bit [7:0] idx, bit [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i iff cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain all expected words, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i iff pending == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_thresholds(bit [2:0] st, bit [1:0] ct);
    write_reg(CFG_STREAM_THR, {5'($urandom), st});
    write_reg(CFG_CONF_THR, {6'($urandom), ct});
    write_reg(8'($urandom_range(2, 255)), 8'($urandom));  // unmapped index: ignored
  endtask

  function automatic bit [10:0] pick_set();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)      return 11'($urandom_range(0, StreamSets - 1));
    else if (r < 6) return 11'($urandom_range(32, 63));
    else if (r < 8) return 11'($urandom_range(64, 95));
    else            return 11'($urandom);
  endfunction

  // Mostly find-then-update pairs on a set, with hot PCs and strided addresses.
  task automatic random_phase(int count);
    bit [10:0] set;
    bit [15:0] mask;
    bit [63:0] pc, addr;
    int        r;
    repeat (count / 2) begin
      set = pick_set();
      r   = $urandom_range(0, 9);
      pc  = (r < 7) ? hot_pcs[$urandom_range(0, 7)] : {$urandom, $urandom};
      if (set < StreamSets && r < 8) begin
        if ($urandom_range(0, 15) == 0) walk_stride[set] = 64'($urandom_range(0, 4)) << 6;
        walk_addr[set] += walk_stride[set];
        addr = walk_addr[set];
      end else begin
        addr = {$urandom, $urandom};
      end
      mask = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'($urandom | $urandom);
      if ($urandom_range(0, 9) < 8) begin
        send_word(1'b0, set, 4'($urandom), mask, {$urandom, $urandom}, {$urandom, $urandom},
                  1'($urandom));
        send_word(1'b1, set, 4'($urandom), 16'($urandom), pc, addr, ($urandom_range(0, 2) == 0));
      end else begin
        // noise: lone updates or finds with random content
        send_word(1'($urandom), set, 4'($urandom), 16'($urandom), pc, addr, 1'($urandom));
        send_word(1'($urandom), 11'($urandom), 4'($urandom), 16'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
      end
    end
  endtask

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    words_sent      = 0;
    for (int i = 0; i < 8; i++) hot_pcs[i] = {$urandom, $urandom};
    for (int i = 0; i < StreamSets; i++) begin
      walk_addr[i]   = {$urandom, $urandom};
      walk_stride[i] = 64'($urandom_range(1, 4)) << 6;
    end
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_thresholds(3'd4, 2'd2);

    // Directed: empty and full masks, invalid top way, extremes of set and fields.
    send_word(1'b0, 11'd5, 4'd0, 16'h0000, '0, '0, 1'b0);
    send_word(1'b0, 11'd5, 4'd0, 16'hffff, '0, '0, 1'b0);      // aging from all zero
    send_word(1'b0, 11'd5, 4'd0, 16'h7fff, '0, '0, 1'b0);      // top way invalid
    send_word(1'b1, 11'd2047, 4'd15, 16'hffff, '1, '1, 1'b1);  // hit, all-ones PC
    send_word(1'b1, 11'd2047, 4'd15, 16'h0000, '0, '1, 1'b0);  // fill evicts that signature
    send_word(1'b0, 11'd2047, 4'd0, 16'hffff, '0, '0, 1'b0);
    // Constant stride in a stream leader: repeat count climbs past the threshold.
    for (int i = 0; i < 8; i++)
      send_word(1'b1, 11'd3, 4'(i), 16'h0, 64'h40, 64'h1000 + 64'(i) * 64'h80, 1'b0);
    send_word(1'b1, 11'd3, 4'd9, 16'h0, 64'h40, 64'h1380, 1'b0);  // zero stride breaks it
    send_word(1'b1, 11'd20, 4'd1, 16'h0, 64'h77, 64'h0, 1'b0);    // BRRIP leader fill
    send_word(1'b1, 11'd100, 4'd2, 16'h0, 64'h77, 64'h0, 1'b0);   // follower fill
    send_word(1'b1, 11'd100, 4'd2, 16'h0, 64'h77, 64'h0, 1'b1);   // train signature
    send_word(1'b1, 11'd100, 4'd2, 16'h0, 64'h77, 64'h0, 1'b1);
    send_word(1'b1, 11'd101, 4'd3, 16'h0, 64'h77, 64'h0, 1'b0);   // confident fill at 0
    send_word(1'b0, 11'd100, 4'd0, 16'hffff, '0, '0, 1'b0);
    drain();

    // Settings run through the extremes of both registers.
    set_thresholds(3'd0, 2'd0);
    random_phase(380);
    drain();
    set_thresholds(3'd7, 2'd3);
    random_phase(380);
    drain();
    set_thresholds(3'd2, 2'd1);
    random_phase(380);
    drain();
    set_thresholds(3'd4, 2'd2);
    random_phase(380);
    drain();
    set_thresholds(3'($urandom), 2'($urandom));
    random_phase(380);
    drain();

    $display("sent %0d words across five threshold settings; %0d result words checked",
             words_sent, checked);
    if (fails == 0) begin
      $display("** drrip_ship_stream_replacement: PASSED **");
    end else begin
      $display("** drrip_ship_stream_replacement: FAILED **");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/drrip_pkg.sv
design/drrip_ship_stream_replacement.sv
tb/drrip_replacement_checker.sv
tb/tb.sv
